>>> sv/u8st_pkg.sv
// ----------------------------------------------------------------------------
// u8st_pkg
// Shared types and constants of the UTF-8 sanitizing copier.
// ----------------------------------------------------------------------------
package u8st_pkg;

   localparam int unsigned CAP_BITS    = 12;
   localparam int unsigned QUEUE_DEPTH = 8;
   localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [CAP_BITS-1:0] CAP_RESET = 12'd128;

   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] LEAD2_LOW   = 8'hC2;
   localparam logic [7:0] LEAD2_HIGH  = 8'hDF;
   localparam logic [7:0] LEAD3_LOW   = 8'hE0;
   localparam logic [7:0] LEAD3_HIGH  = 8'hEF;
   localparam logic [7:0] LEAD4_LOW   = 8'hF0;
   localparam logic [7:0] LEAD4_HIGH  = 8'hF4;
   localparam logic [7:0] CONT_MASK   = 8'hC0;
   localparam logic [7:0] CONT_CODE   = 8'h80;

   // one emitted sequence: byte k in bits 8k+7..8k, last_idx = length - 1
   typedef struct packed {
      logic [31:0] bytes;
      logic [1:0]  last_idx;
      logic        is_last;
   } group_type;

   function automatic logic [2:0] seq_length(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      if (b < ASCII_LIMIT) len = 3'd1;
      else if (b >= LEAD2_LOW && b <= LEAD2_HIGH) len = 3'd2;
      else if (b >= LEAD3_LOW && b <= LEAD3_HIGH) len = 3'd3;
      else if (b >= LEAD4_LOW && b <= LEAD4_HIGH) len = 3'd4;
      return len;
   endfunction

endpackage

>>> sv/utf8_sanitize_truncate.sv
// ----------------------------------------------------------------------------
// utf8_sanitize_truncate
// Validating, truncating UTF-8 byte copier.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle while req_full is low and emits only whole
// UTF-8 sequences that fit in csr_wdata-sized destination space (terminator
// included); the zero byte always comes out last with rsp_is_last set. The
// front classifies and assembles sequences; an 8-entry sequence queue feeds
// the back end, which emits one word per cycle from its output register while
// rsp_pop keeps up, giving a sustained rate of one byte per cycle in and out.
// Each sequence reaches the outputs through the queue and the output register.
// req_full rises only when the queue fills while results are being stalled.
// ----------------------------------------------------------------------------
module utf8_sanitize_truncate import u8st_pkg::*; #(
   parameter int unsigned COUNT_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CAP_BITS-1:0] csr_wdata,
   input  logic                req_push,
   output logic                req_full,
   input  logic [7:0]          req_in_byte,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_is_last
);

   logic      accept;
   logic      grp_push;
   group_type grp;
   group_type head;
   logic      q_full, q_empty, q_pop;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   u8st_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .grp_push  (grp_push),
      .grp       (grp)
   );

   u8st_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (grp_push),
      .push_data (grp),
      .full      (q_full),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty)
   );

   u8st_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_last  (rsp_is_last)
   );

endmodule

>>> sv/u8st_front.sv
// ----------------------------------------------------------------------------
// u8st_front
// Classifies source bytes, assembles sequences and applies the fit rule.
// ----------------------------------------------------------------------------
module u8st_front import u8st_pkg::*; #(
   parameter int unsigned COUNT_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CAP_BITS-1:0] csr_wdata,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   output logic                grp_push,
   output group_type           grp
);

   localparam int unsigned CW = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 1;

   logic [CAP_BITS-1:0]   capacity_ff;
   logic [23:0]           pend_ff, pend_in;
   logic [2:0]            exp_ff, exp_in;
   logic [1:0]            coll_ff, coll_in;
   logic [COUNT_BITS-1:0] wc_ff, wc_in;
   logic                  stop_ff, stop_in;

   logic        emit_go;
   logic [31:0] emit_bytes;
   logic [2:0]  emit_n;
   logic        treat_new;
   logic [2:0]  len;
   logic [31:0] merged;
   logic [CW-1:0] cap_w, lim_w, eff_w, sum_w;
   logic        fits;

   assign csr_ready = 1'b1;

   assign merged = {8'h00, pend_ff} | (32'(in_byte) << {coll_ff, 3'b000});
   assign len    = seq_length(in_byte);

   assign cap_w = CW'(capacity_ff);
   assign lim_w = (CW'(1) << COUNT_BITS) - CW'(1);
   assign eff_w = (cap_w < lim_w) ? cap_w : lim_w;
   assign sum_w = CW'(wc_ff) + CW'(emit_n);
   assign fits  = sum_w < eff_w;

   always_comb begin
      pend_in    = pend_ff;
      exp_in     = exp_ff;
      coll_in    = coll_ff;
      wc_in      = wc_ff;
      stop_in    = stop_ff;
      emit_go    = 1'b0;
      emit_bytes = 32'h0;
      emit_n     = 3'd1;
      treat_new  = 1'b1;
      grp_push   = 1'b0;
      grp        = '{bytes: 32'h0, last_idx: 2'd0, is_last: 1'b0};

      if (in_byte == 8'h00) begin
         pend_in  = 24'h0;
         exp_in   = 3'd0;
         coll_in  = 2'd0;
         wc_in    = '0;
         stop_in  = 1'b0;
         grp_push = accept;
         grp      = '{bytes: 32'h0, last_idx: 2'd0, is_last: 1'b1};
      end else if (!stop_ff) begin
         if (exp_ff != 3'd0) begin
            if ((in_byte & CONT_MASK) == CONT_CODE) begin
               treat_new = 1'b0;
               if ({1'b0, coll_ff} + 3'd1 >= exp_ff) begin
                  emit_go    = 1'b1;
                  emit_bytes = merged;
                  emit_n     = exp_ff;
               end else begin
                  pend_in = merged[23:0];
                  coll_in = coll_ff + 2'd1;
               end
            end else begin
               pend_in = 24'h0;
               exp_in  = 3'd0;
               coll_in = 2'd0;
            end
         end
         if (treat_new) begin
            if (len == 3'd1) begin
               emit_go    = 1'b1;
               emit_bytes = 32'(in_byte);
               emit_n     = 3'd1;
            end else if (len != 3'd0) begin
               pend_in = 24'(in_byte);
               exp_in  = len;
               coll_in = 2'd1;
            end
         end
         if (emit_go) begin
            pend_in = 24'h0;
            exp_in  = 3'd0;
            coll_in = 2'd0;
            if (fits) begin
               wc_in    = wc_ff + COUNT_BITS'(emit_n);
               grp_push = accept;
               grp      = '{bytes: emit_bytes, last_idx: 2'(emit_n - 3'd1), is_last: 1'b0};
            end else begin
               stop_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         pend_ff     <= 24'h0;
         exp_ff      <= 3'd0;
         coll_ff     <= 2'd0;
         wc_ff       <= '0;
         stop_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            capacity_ff <= csr_wdata;
         end
         if (accept) begin
            pend_ff <= pend_in;
            exp_ff  <= exp_in;
            coll_ff <= coll_in;
            wc_ff   <= wc_in;
            stop_ff <= stop_in;
         end
      end
   end

endmodule

>>> sv/u8st_queue.sv
// ----------------------------------------------------------------------------
// u8st_queue
// Short queue of assembled sequences between front and back.
// ----------------------------------------------------------------------------
module u8st_queue import u8st_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_data,
   output logic      full,
   input  logic      pop,
   output group_type head,
   output logic      empty
);

   group_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ff, rd_ff;
   logic [QPTR_BITS:0]   cnt_ff;
   logic                 do_push, do_pop;

   assign full    = (cnt_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + QPTR_BITS'(1);
         if (do_pop)  rd_ff <= rd_ff + QPTR_BITS'(1);
         unique case ({do_push, do_pop})
            2'b10:   cnt_ff <= cnt_ff + (QPTR_BITS+1)'(1);
            2'b01:   cnt_ff <= cnt_ff - (QPTR_BITS+1)'(1);
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

>>> sv/u8st_back.sv
// ----------------------------------------------------------------------------
// u8st_back
// Splits queued sequences into single words on the result register.
// ----------------------------------------------------------------------------
module u8st_back import u8st_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  group_type  head,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_last
);

   logic [1:0] idx_ff;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       load;
   logic       at_end;

   assign rsp_empty    = !valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_is_last  = last_ff;

   assign load   = !q_empty && (!valid_ff || rsp_pop);
   assign at_end = (idx_ff == head.last_idx);
   assign q_pop  = load && at_end;

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head.bytes[{idx_ff, 3'b000} +: 8];
         last_ff <= head.is_last && at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= at_end ? 2'd0 : idx_ff + 2'd1;
         end else if (rsp_pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule

>>> sv/u8st_checker.sv
// ----------------------------------------------------------------------------
// u8st_checker
// Port-level checks of the UTF-8 copier, bound to the top level.
// ----------------------------------------------------------------------------
module u8st_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_is_last,
   input logic       req_full
);

   a_last_is_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_last) |-> (rsp_out_byte == 8'h00))
      else $error("terminator word is not zero");

   a_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_is_last) |-> (rsp_out_byte != 8'h00))
      else $error("zero word without last flag");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_out_byte) && $stable(rsp_is_last)))
      else $error("stalled result word changed");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && !req_full))
      else $error("not idle after reset");

endmodule

bind utf8_sanitize_truncate u8st_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_empty    (rsp_empty),
   .rsp_pop      (rsp_pop),
   .rsp_out_byte (rsp_out_byte),
   .rsp_is_last  (rsp_is_last),
   .req_full     (req_full)
);
